@@ hdl/ndi_pkg.sv @@
// Shared types, codes and saturation helper for the Newton interpolation engine.
package ndi_pkg;

    localparam int DATA_W = 32;
    localparam int WIDE_W = DATA_W + 1;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    typedef struct packed {
        logic start;
        logic mul;
    } unit_req_t;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } clamp_t;

    function automatic clamp_t clamp_mag(input logic neg, input logic [WIDE_W-1:0] mag);
        clamp_t r;
        logic [WIDE_W-1:0] negv;
        negv = -mag;
        r.sat = 1'b0;
        if (neg)
        begin
            if (mag > {1'b0, 1'b1, {(DATA_W-1){1'b0}}})
            begin
                r.sat = 1'b1;
                r.val = {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                r.val = negv[DATA_W-1:0];
            end
        end
        else
        begin
            if (mag > {2'b00, {(DATA_W-1){1'b1}}})
            begin
                r.sat = 1'b1;
                r.val = {1'b0, {(DATA_W-1){1'b1}}};
            end
            else
            begin
                r.val = mag[DATA_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/ndi_unit.sv @@
// Shared bit-serial unit: restoring divider and shift-add multiplier on magnitudes.
module ndi_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ndi_pkg::unit_req_t               req,
    input  logic [ndi_pkg::WIDE_W-1:0]       a,
    input  logic [ndi_pkg::WIDE_W-1:0]       b,
    output logic                             done,
    output logic [ndi_pkg::WIDE_W-1:0]       mag
);

    localparam int WW    = ndi_pkg::WIDE_W;
    localparam int QW    = WW + FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);
    localparam int ACC_W = 2 * WW;

    logic             busy_reg;
    logic             mul_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [QW-1:0]    sh_reg;
    logic [WW-1:0]    opd_reg;

    logic [WW:0]      trial;
    logic             fits;
    logic [ACC_W-1:0] acc_step;

    assign trial    = {acc_reg[WW-1:0], sh_reg[QW-1]};
    assign fits     = trial >= {1'b0, opd_reg};
    assign acc_step = {acc_reg[ACC_W-2:0], 1'b0}
                      + (sh_reg[QW-1] ? {{WW{1'b0}}, opd_reg} : {ACC_W{1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mul_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                mul_reg  <= req.mul;
                cnt_reg  <= req.mul ? CNT_W'(WW) : CNT_W'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            if (req.mul)
            begin
                opd_reg <= a;
                sh_reg  <= {b, {FRAC_BITS{1'b0}}};
            end
            else
            begin
                opd_reg <= b;
                sh_reg  <= {a, {FRAC_BITS{1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            if (mul_reg)
            begin
                acc_reg <= acc_step;
                sh_reg  <= {sh_reg[QW-2:0], 1'b0};
            end
            else
            begin
                acc_reg[WW-1:0] <= fits ? trial[WW-1:0] - opd_reg : trial[WW-1:0];
                sh_reg          <= {sh_reg[QW-2:0], fits};
            end
        end
    end

    always_comb
    begin
        if (mul_reg)
            mag = (|acc_reg[ACC_W-1:WW+FRAC_BITS]) ? {WW{1'b1}}
                                                   : acc_reg[WW+FRAC_BITS-1:FRAC_BITS];
        else
            mag = (|sh_reg[QW-1:WW]) ? {WW{1'b1}} : sh_reg[WW-1:0];
    end

    assign done = done_reg;

endmodule

@@ hdl/newton_divided_difference_interp_top.sv @@
// Newton divided-difference interpolation engine, top level with sequencer and tables.
// Add scans the table for a duplicate x, then runs the divided-difference divides; evaluate
// runs a Horner loop of multiplies; both use the one shared bit-serial unit. One transaction
// at a time; s_tready is high only while the sequencer is idle, from the cycle after the
// result is registered, later while m_tready holds the last result.
// rst_n asynchronously empties the table and clears m_tvalid; table memories keep contents.
module newton_divided_difference_interp_top #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_value[31:0], y_value[63:32]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_value[31:0], point_count above, zero pad
    output logic [((32 + $clog2(MAX_POINTS + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int DW = ndi_pkg::DATA_W;
    localparam int WW = ndi_pkg::WIDE_W;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int OW = ((DW + CW + 7) / 8) * 8;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DUP_RD  = 4'd1;
    localparam logic [3:0] S_DUP_CMP = 4'd2;
    localparam logic [3:0] S_ADD_RD  = 4'd3;
    localparam logic [3:0] S_ADD_LD  = 4'd4;
    localparam logic [3:0] S_ADD_WT  = 4'd5;
    localparam logic [3:0] S_ADD_FIN = 4'd6;
    localparam logic [3:0] S_EV_RD0  = 4'd7;
    localparam logic [3:0] S_EV_LD0  = 4'd8;
    localparam logic [3:0] S_EV_RD   = 4'd9;
    localparam logic [3:0] S_EV_LD   = 4'd10;
    localparam logic [3:0] S_EV_WT   = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          sat_reg, sat_next;
    logic          neg_reg, neg_next;
    logic [DW-1:0] xin_reg, xin_next;
    logic [DW-1:0] cur_reg, cur_next;
    logic [DW-1:0] c_reg, c_next;
    logic [DW-1:0] fin_val_reg, fin_val_next;
    logic [1:0]    fin_st_reg, fin_st_next;
    logic          m_tvalid_reg;
    logic [OW-1:0] m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    logic [DW-1:0] xs_mem [MAX_POINTS];
    logic [DW-1:0] ad_mem [MAX_POINTS];
    logic [DW-1:0] cf_mem [MAX_POINTS];
    logic [DW-1:0] xs_rdata, ad_rdata, cf_rdata;
    logic [AW-1:0] xs_raddr, ad_raddr, cf_raddr, ad_waddr;
    logic          xs_we, ad_we, cf_we;
    logic [DW-1:0] ad_wdata;

    logic [CW-1:0] idx_m1, cnt_m1, cnt_mi;
    logic [WW-1:0] num, den, dif, num_mag, den_mag, cur_mag, dif_mag, cur_w;
    logic [WW-1:0] sum;

    ndi_pkg::unit_req_t req;
    logic [WW-1:0]      op_a, op_b, u_mag;
    logic               u_done;
    ndi_pkg::clamp_t    cl;

    ndi_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .a     (op_a),
        .b     (op_b),
        .done  (u_done),
        .mag   (u_mag)
    );

    assign idx_m1 = idx_reg - 1'b1;
    assign cnt_m1 = cnt_reg - 1'b1;
    assign cnt_mi = cnt_reg - idx_reg;

    assign cur_w   = {cur_reg[DW-1], cur_reg};
    assign num     = cur_w - {ad_rdata[DW-1], ad_rdata};
    assign den     = {xin_reg[DW-1], xin_reg} - {xs_rdata[DW-1], xs_rdata};
    assign dif     = den;
    assign num_mag = num[WW-1] ? -num : num;
    assign den_mag = den[WW-1] ? -den : den;
    assign dif_mag = den_mag;
    assign cur_mag = cur_w[WW-1] ? -cur_w : cur_w;
    assign cl      = ndi_pkg::clamp_mag(neg_reg, u_mag);
    assign sum     = {c_reg[DW-1], c_reg} + {cl.val[DW-1], cl.val};

    always_comb
    begin
        xs_raddr = '0;
        ad_raddr = idx_m1[AW-1:0];
        cf_raddr = idx_m1[AW-1:0];
        case (state_reg)
            S_DUP_RD: xs_raddr = idx_reg[AW-1:0];
            S_ADD_RD: xs_raddr = cnt_mi[AW-1:0];
            S_EV_RD0: cf_raddr = cnt_m1[AW-1:0];
            S_EV_RD:  xs_raddr = idx_m1[AW-1:0];
            default:  xs_raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (xs_we)
            xs_mem[cnt_reg[AW-1:0]] <= xin_reg;
        if (ad_we)
            ad_mem[ad_waddr] <= ad_wdata;
        if (cf_we)
            cf_mem[cnt_reg[AW-1:0]] <= cur_reg;
        xs_rdata <= xs_mem[xs_raddr];
        ad_rdata <= ad_mem[ad_raddr];
        cf_rdata <= cf_mem[cf_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        sat_next     = sat_reg;
        neg_next     = neg_reg;
        xin_next     = xin_reg;
        cur_next     = cur_reg;
        c_next       = c_reg;
        fin_val_next = fin_val_reg;
        fin_st_next  = fin_st_reg;
        xs_we        = 1'b0;
        ad_we        = 1'b0;
        cf_we        = 1'b0;
        ad_waddr     = idx_m1[AW-1:0];
        ad_wdata     = cur_reg;
        req          = '0;
        op_a         = num_mag;
        op_b         = den_mag;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    xin_next     = s_tdata[31:0];
                    cur_next     = s_tdata[63:32];
                    sat_next     = 1'b0;
                    fin_val_next = '0;
                    fin_st_next  = ndi_pkg::ST_OK;
                    state_next   = S_DONE;
                    case (s_tuser)
                        ndi_pkg::OP_CLEAR: cnt_next = '0;
                        ndi_pkg::OP_ADD:
                        begin
                            if (cnt_reg >= CW'(MAX_POINTS))
                                fin_st_next = ndi_pkg::ST_FULL;
                            else if (cnt_reg == '0)
                            begin
                                idx_next   = CW'(1);
                                state_next = S_ADD_RD;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DUP_RD;
                            end
                        end
                        ndi_pkg::OP_EVAL:
                        begin
                            if (cnt_reg != '0)
                                state_next = S_EV_RD0;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_DUP_RD: state_next = S_DUP_CMP;
            S_DUP_CMP:
            begin
                if (xs_rdata == xin_reg)
                begin
                    fin_st_next = ndi_pkg::ST_DUP;
                    state_next  = S_DONE;
                end
                else if (idx_reg + 1'b1 == cnt_reg)
                begin
                    idx_next   = CW'(1);
                    state_next = S_ADD_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DUP_RD;
                end
            end
            S_ADD_RD: state_next = (idx_reg > cnt_reg) ? S_ADD_FIN : S_ADD_LD;
            S_ADD_LD:
            begin
                req.start  = 1'b1;
                neg_next   = num[WW-1] ^ den[WW-1];
                ad_we      = 1'b1;
                state_next = S_ADD_WT;
            end
            S_ADD_WT:
            begin
                if (u_done)
                begin
                    cur_next   = cl.val;
                    sat_next   = sat_reg | cl.sat;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_ADD_RD;
                end
            end
            S_ADD_FIN:
            begin
                xs_we       = 1'b1;
                ad_we       = 1'b1;
                cf_we       = 1'b1;
                ad_waddr    = cnt_reg[AW-1:0];
                cnt_next    = cnt_reg + 1'b1;
                fin_st_next = sat_reg ? ndi_pkg::ST_SAT : ndi_pkg::ST_OK;
                state_next  = S_DONE;
            end
            S_EV_RD0: state_next = S_EV_LD0;
            S_EV_LD0:
            begin
                cur_next   = cf_rdata;
                idx_next   = cnt_m1;
                state_next = S_EV_RD;
            end
            S_EV_RD:
            begin
                if (idx_reg == '0)
                begin
                    fin_val_next = cur_reg;
                    fin_st_next  = sat_reg ? ndi_pkg::ST_SAT : ndi_pkg::ST_OK;
                    state_next   = S_DONE;
                end
                else
                    state_next = S_EV_LD;
            end
            S_EV_LD:
            begin
                req.start  = 1'b1;
                req.mul    = 1'b1;
                op_a       = cur_mag;
                op_b       = dif_mag;
                neg_next   = cur_reg[DW-1] ^ dif[WW-1];
                c_next     = cf_rdata;
                state_next = S_EV_WT;
            end
            S_EV_WT:
            begin
                if (u_done)
                begin
                    sat_next = sat_reg | cl.sat;
                    if (sum[WW-1] && !sum[DW-1])
                    begin
                        cur_next = {1'b1, {(DW-1){1'b0}}};
                        sat_next = 1'b1;
                    end
                    else if (!sum[WW-1] && sum[DW-1])
                    begin
                        cur_next = {1'b0, {(DW-1){1'b1}}};
                        sat_next = 1'b1;
                    end
                    else
                        cur_next = sum[DW-1:0];
                    idx_next   = idx_m1;
                    state_next = S_EV_RD;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        sat_reg     <= sat_next;
        neg_reg     <= neg_next;
        xin_reg     <= xin_next;
        cur_reg     <= cur_next;
        c_reg       <= c_next;
        fin_val_reg <= fin_val_next;
        fin_st_reg  <= fin_st_next;
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= {{(OW - DW - CW){1'b0}}, cnt_reg, fin_val_reg};
            m_tuser_reg <= fin_st_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
